// ===== hdl/xrs_pkg.sv =====
// xrs_pkg: shared types, constants and the control store for the xoroshiro128+ generator
// depends on nothing; used by the channel interfaces and xoroshiro128plus_generator_top
`default_nettype none

package xrs_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned FuncW = 2;
  localparam int unsigned SeedW = 32;
  localparam int unsigned PcW   = 5;
  localparam int unsigned CntW  = 7;

  localparam logic [WordW-1:0]   JumpPolyLo = 64'hbeac0467eba5facb;
  localparam logic [WordW-1:0]   JumpPolyHi = 64'hd86b048b86aa9922;
  localparam logic [2*WordW-1:0] JumpPoly   = {JumpPolyHi, JumpPolyLo};
  localparam logic [WordW-1:0]   SmGamma    = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0]   SmMul1     = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0]   SmMul2     = 64'h94d049bb133111eb;
  localparam logic [WordW-1:0]   ResetSeed  = 64'd42;
  localparam logic [CntW-1:0]    JumpLast   = '1;

  typedef enum logic [FuncW-1:0] {
    FUNC_NEXT   = 2'd0,
    FUNC_JUMP   = 2'd1,
    FUNC_RESEED = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_NEXT,
    OP_JINIT,
    OP_JSTEP,
    OP_JDONE,
    OP_GAMMA,
    OP_XS30,
    OP_MLL,
    OP_MLH,
    OP_MHL,
    OP_PSET,
    OP_PADD,
    OP_XS27,
    OP_XS31,
    OP_STORE
  } op_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_FIRST,
    COND_LOOP
  } cond_e;

  typedef enum logic {
    MSEL_MUL1,
    MSEL_MUL2
  } msel_e;

  typedef struct packed {
    op_e            op;
    msel_e          msel;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           last;
  } ctrl_t;

  typedef struct packed {
    logic [WordW-1:0] s1;
    logic [WordW-1:0] s0;
  } state_t;

  localparam logic [PcW-1:0] PcNext   = 5'd0;
  localparam logic [PcW-1:0] PcNone   = 5'd1;
  localparam logic [PcW-1:0] PcJump   = 5'd2;
  localparam logic [PcW-1:0] PcJLoop  = 5'd3;
  localparam logic [PcW-1:0] PcReseed = 5'd5;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int unsigned k);
    rotl = (x << k) | (x >> (WordW - k));
  endfunction

  function automatic state_t advance(input state_t s);
    state_t           r;
    logic [WordW-1:0] b;
    b    = s.s1 ^ s.s0;
    r.s0 = rotl(s.s0, 55) ^ b ^ (b << 14);
    r.s1 = rotl(b, 36);
    return r;
  endfunction

  function automatic logic [PcW-1:0] entry_pc(input func_e f);
    unique case (f)
      FUNC_NEXT:   entry_pc = PcNext;
      FUNC_JUMP:   entry_pc = PcJump;
      FUNC_RESEED: entry_pc = PcReseed;
      FUNC_NONE:   entry_pc = PcNone;
    endcase
  endfunction

  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    unique case (pc)
      5'd0:    ucode = '{OP_NEXT,  MSEL_MUL1, COND_NONE,   '0,       1'b1};
      5'd1:    ucode = '{OP_NOP,   MSEL_MUL1, COND_NONE,   '0,       1'b1};
      5'd2:    ucode = '{OP_JINIT, MSEL_MUL1, COND_NONE,   '0,       1'b0};
      5'd3:    ucode = '{OP_JSTEP, MSEL_MUL1, COND_LOOP,   PcJLoop,  1'b0};
      5'd4:    ucode = '{OP_JDONE, MSEL_MUL1, COND_NONE,   '0,       1'b1};
      5'd5:    ucode = '{OP_GAMMA, MSEL_MUL1, COND_NONE,   '0,       1'b0};
      5'd6:    ucode = '{OP_XS30,  MSEL_MUL1, COND_NONE,   '0,       1'b0};
      5'd7:    ucode = '{OP_MLL,   MSEL_MUL1, COND_NONE,   '0,       1'b0};
      5'd8:    ucode = '{OP_PSET,  MSEL_MUL1, COND_NONE,   '0,       1'b0};
      5'd9:    ucode = '{OP_MLH,   MSEL_MUL1, COND_NONE,   '0,       1'b0};
      5'd10:   ucode = '{OP_PADD,  MSEL_MUL1, COND_NONE,   '0,       1'b0};
      5'd11:   ucode = '{OP_MHL,   MSEL_MUL1, COND_NONE,   '0,       1'b0};
      5'd12:   ucode = '{OP_PADD,  MSEL_MUL1, COND_NONE,   '0,       1'b0};
      5'd13:   ucode = '{OP_XS27,  MSEL_MUL1, COND_NONE,   '0,       1'b0};
      5'd14:   ucode = '{OP_MLL,   MSEL_MUL2, COND_NONE,   '0,       1'b0};
      5'd15:   ucode = '{OP_PSET,  MSEL_MUL2, COND_NONE,   '0,       1'b0};
      5'd16:   ucode = '{OP_MLH,   MSEL_MUL2, COND_NONE,   '0,       1'b0};
      5'd17:   ucode = '{OP_PADD,  MSEL_MUL2, COND_NONE,   '0,       1'b0};
      5'd18:   ucode = '{OP_MHL,   MSEL_MUL2, COND_NONE,   '0,       1'b0};
      5'd19:   ucode = '{OP_PADD,  MSEL_MUL2, COND_NONE,   '0,       1'b0};
      5'd20:   ucode = '{OP_XS31,  MSEL_MUL2, COND_NONE,   '0,       1'b0};
      5'd21:   ucode = '{OP_STORE, MSEL_MUL2, COND_FIRST,  PcReseed, 1'b0};
      5'd22:   ucode = '{OP_NOP,   MSEL_MUL1, COND_ALWAYS, PcJump,   1'b0};
      default: ucode = '{OP_NOP,   MSEL_MUL1, COND_NONE,   '0,       1'b1};
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hdl/xrs_req_if.sv =====
// xrs_req_if: request channel carrying func and seed_value beats
// depends on xrs_pkg for field widths
`default_nettype none

interface xrs_req_if;
  logic                           valid;
  logic                           ready;
  logic [xrs_pkg::FuncW-1:0]      func;
  logic [xrs_pkg::SeedW-1:0]      seed_value;

  modport source (output valid, output func, output seed_value, input ready);
  modport sink   (input valid, input func, input seed_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/xrs_rsp_if.sv =====
// xrs_rsp_if: response channel carrying random_value beats
// depends on xrs_pkg for field widths
`default_nettype none

interface xrs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [xrs_pkg::WordW-1:0]      random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/xoroshiro128plus_generator_top.sv =====
// xoroshiro128plus_generator_top: microcoded xoroshiro128+ generator with jump and reseed
// depends on xrs_pkg, xrs_req_if and xrs_rsp_if
//
//   channel    dir  beat fields
//   req_i      in   func, seed_value
//   rsp_o      out  random_value
//   zero_seed  in   zero_seed_we_i, zero_seed_value_i
//
// next: one beat per cycle back to back unless rsp_o stalls; jump: the 128 step jump loop;
// reseed: the 32x32 multiplier (3 products per 64-bit multiply), then the jump loop
// after reset the sequencer runs a reseed with seed 42 while req_i is not ready
// a finished result waits in the output register; only the final step stalls on rsp_o
`default_nettype none

module xoroshiro128plus_generator_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       zero_seed_we_i,
  input  wire logic [63:0]                zero_seed_value_i,
  xrs_req_if.sink                         req_i,
  xrs_rsp_if.source                       rsp_o
);
  import xrs_pkg::*;

  // control
  logic                busy_q, init_q, half_q, out_valid_q;
  logic [PcW-1:0]      pc_q;
  logic [CntW-1:0]     cnt_q;
  logic [WordW-1:0]    zero_seed_q, x_q;

  // datapath
  state_t              s_q, acc_q;
  logic [WordW-1:0]    z_q, p_q, prod_q, res_q;

  ctrl_t               cw;
  logic                out_free, step_en, finish, accept, cond_hit;
  logic [WordW-1:0]    mconst, seed_sel, x_sum;
  logic [HalfW-1:0]    mul_a, mul_b;
  state_t              s_adv;

  always_comb begin
    cw       = ucode(pc_q);
    out_free = !out_valid_q || rsp_o.ready;
    step_en  = busy_q && (!cw.last || out_free);
    finish   = step_en && cw.last;
    accept   = req_i.valid && (!busy_q || finish);
    unique case (cw.cond)
      COND_NONE:   cond_hit = 1'b0;
      COND_ALWAYS: cond_hit = 1'b1;
      COND_FIRST:  cond_hit = !half_q;
      COND_LOOP:   cond_hit = (cnt_q != JumpLast);
    endcase
    mconst   = (cw.msel == MSEL_MUL2) ? SmMul2 : SmMul1;
    mul_a    = (cw.op == OP_MHL) ? z_q[WordW-1:HalfW] : z_q[HalfW-1:0];
    mul_b    = (cw.op == OP_MLH) ? mconst[WordW-1:HalfW] : mconst[HalfW-1:0];
    seed_sel = (req_i.seed_value == '0) ? zero_seed_q : {{(WordW-SeedW){1'b0}}, req_i.seed_value};
    x_sum    = x_q + SmGamma;
    s_adv    = advance(s_q);
  end

  assign req_i.ready        = !busy_q || finish;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.random_value = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      init_q      <= 1'b1;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= PcReseed;
      cnt_q       <= '0;
      zero_seed_q <= '0;
      x_q         <= ResetSeed;
    end else begin
      if (zero_seed_we_i) begin
        zero_seed_q <= zero_seed_value_i;
      end
      if (finish && !init_q) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        init_q <= 1'b0;
      end
      if (accept) begin
        pc_q <= entry_pc(func_e'(req_i.func));
      end else if (step_en) begin
        pc_q <= cond_hit ? cw.target : pc_q + 1'b1;
      end
      if (accept) begin
        half_q <= 1'b0;
      end else if (step_en && cw.op == OP_STORE) begin
        half_q <= 1'b1;
      end
      if (step_en && cw.op == OP_JINIT) begin
        cnt_q <= '0;
      end else if (step_en && cw.op == OP_JSTEP) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (accept) begin
        x_q <= seed_sel;
      end else if (step_en && cw.op == OP_GAMMA) begin
        x_q <= x_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      unique case (cw.op)
        OP_NOP:   ;
        OP_NEXT:  s_q <= s_adv;
        OP_JINIT: acc_q <= '0;
        OP_JSTEP: begin
          if (JumpPoly[cnt_q]) begin
            acc_q <= acc_q ^ s_q;
          end
          s_q <= s_adv;
        end
        OP_JDONE: s_q <= acc_q;
        OP_GAMMA: z_q <= x_sum;
        OP_XS30:  z_q <= z_q ^ (z_q >> 30);
        OP_MLL, OP_MLH, OP_MHL: prod_q <= mul_a * mul_b;
        OP_PSET:  p_q <= prod_q;
        OP_PADD:  p_q[WordW-1:HalfW] <= p_q[WordW-1:HalfW] + prod_q[HalfW-1:0];
        OP_XS27:  z_q <= p_q ^ (p_q >> 27);
        OP_XS31:  z_q <= p_q ^ (p_q >> 31);
        OP_STORE: begin
          if (!half_q) begin
            s_q.s0 <= z_q;
          end else begin
            s_q.s1 <= z_q;
          end
        end
        default:  ;
      endcase
      if (finish) begin
        res_q <= (cw.op == OP_NEXT) ? s_q.s0 + s_q.s1 : '0;
      end
    end
  end

endmodule

`default_nettype wire
